// File: sv/gmi_pkg.sv
// Shared types and constants for the GF(2) matrix inverse unit.
package gmi_pkg;

  localparam int unsigned ROW_W = 32;

  typedef struct packed {
    logic load;
    logic init;
    logic pick;
    logic apply;
    logic emit;
    logic sing;
  } cmd_t;

  typedef struct packed {
    logic no_pivot;
  } status_t;

endpackage

// File: sv/gmi_datapath.sv
// Row storage, pivot selection and parallel row elimination for the GF(2) inverse.
module gmi_datapath #(
  parameter int unsigned DIM = 32,
  parameter int unsigned CW  = $clog2(DIM)
) (
  input  logic                     clk,
  input  gmi_pkg::cmd_t            cmd,
  input  logic [CW-1:0]            idx,
  input  logic [gmi_pkg::ROW_W-1:0] in_row_bits,
  output gmi_pkg::status_t         status,
  output logic [gmi_pkg::ROW_W-1:0] out_inverse_row
);

  logic [DIM-1:0] left_r  [DIM];
  logic [DIM-1:0] right_r [DIM];
  logic [DIM-1:0] used_r;
  logic [DIM-1:0] piv_oh_r;
  logic [DIM-1:0] piv_left_r;
  logic [DIM-1:0] piv_right_r;
  logic [gmi_pkg::ROW_W-1:0] out_row_r;

  logic [DIM-1:0] in_row_m;
  logic [DIM-1:0] colbit;
  logic [DIM-1:0] cand;
  logic [DIM-1:0] cand_oh;
  logic [DIM-1:0] sel_left;
  logic [DIM-1:0] sel_right;
  logic [DIM-1:0] emit_right;
  logic [gmi_pkg::ROW_W-1:0] emit_row;

  // Bits of the incoming row at or above DIM are dropped; missing columns are zero.
  generate
    if (DIM > gmi_pkg::ROW_W) begin : g_in_wide
      assign in_row_m = {{(DIM - gmi_pkg::ROW_W){1'b0}}, in_row_bits};
      assign emit_row = emit_right[gmi_pkg::ROW_W-1:0];
    end else if (DIM == gmi_pkg::ROW_W) begin : g_in_eq
      assign in_row_m = in_row_bits;
      assign emit_row = emit_right;
    end else begin : g_in_narrow
      assign in_row_m = in_row_bits[DIM-1:0];
      assign emit_row = {{(gmi_pkg::ROW_W - DIM){1'b0}}, emit_right};
    end
  endgenerate

  // Each row lane looks at its own bit in the current column.
  always_comb begin
    for (int r = 0; r < DIM; r++) begin
      colbit[r] = left_r[r][idx];
    end
  end

  // The first unused row with a one in the column becomes the pivot. Any
  // pivot choice gives the same inverse, so no row swap is needed.
  assign cand    = colbit & ~used_r;
  assign cand_oh = cand & (~cand + DIM'(1));
  assign status.no_pivot = (cand == '0);

  always_comb begin
    sel_left   = '0;
    sel_right  = '0;
    emit_right = '0;
    for (int r = 0; r < DIM; r++) begin
      if (cand_oh[r]) begin
        sel_left  = sel_left | left_r[r];
        sel_right = sel_right | right_r[r];
      end
      // After elimination the left half is a permutation, so exactly one row
      // has a one in the emitted column; its right half is that inverse row.
      if (colbit[r]) begin
        emit_right = emit_right | right_r[r];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pick) begin
      piv_oh_r    <= cand_oh;
      piv_left_r  <= sel_left;
      piv_right_r <= sel_right;
    end
    if (cmd.init) begin
      used_r <= '0;
    end else if (cmd.apply) begin
      used_r <= used_r | piv_oh_r;
    end
    for (int r = 0; r < DIM; r++) begin
      if (cmd.load && (idx == CW'(r))) begin
        left_r[r] <= in_row_m;
      end else if (cmd.apply && !piv_oh_r[r] && colbit[r]) begin
        left_r[r] <= left_r[r] ^ piv_left_r;
      end
      if (cmd.init) begin
        right_r[r] <= DIM'(1) << r;
      end else if (cmd.apply && !piv_oh_r[r] && colbit[r]) begin
        right_r[r] <= right_r[r] ^ piv_right_r;
      end
    end
    if (cmd.sing) begin
      out_row_r <= '0;
    end else if (cmd.emit) begin
      out_row_r <= emit_row;
    end
  end

  assign out_inverse_row = out_row_r;

endmodule

// File: sv/gmi_ctrl.sv
// Sequencer for loading, column elimination and result output of the GF(2) inverse.
module gmi_ctrl #(
  parameter int unsigned DIM = 32,
  parameter int unsigned CW  = $clog2(DIM)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             out_singular,
  output logic             out_last_row,
  output gmi_pkg::cmd_t    cmd,
  output logic [CW-1:0]    idx,
  input  gmi_pkg::status_t status
);

  localparam logic [2:0] ST_LOAD  = 3'd0;
  localparam logic [2:0] ST_PICK  = 3'd1;
  localparam logic [2:0] ST_APPLY = 3'd2;
  localparam logic [2:0] ST_EMIT  = 3'd3;
  localparam logic [2:0] ST_SING  = 3'd4;

  logic [2:0]    state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          out_sing_r, out_sing_nxt;
  logic          out_last_r, out_last_nxt;
  logic          cnt_last;
  logic          out_free;

  assign cnt_last = (cnt_r == CW'(DIM - 1));
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_sing_nxt  = out_sing_r;
    out_last_nxt  = out_last_r;
    cmd           = '0;
    in_ready      = 1'b0;
    case (state_r)
      ST_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (cnt_last) begin
            cmd.init  = 1'b1;
            cnt_nxt   = '0;
            state_nxt = ST_PICK;
          end else begin
            cnt_nxt = cnt_r + CW'(1);
          end
        end
      end
      ST_PICK: begin
        cmd.pick = 1'b1;
        state_nxt = status.no_pivot ? ST_SING : ST_APPLY;
      end
      ST_APPLY: begin
        cmd.apply = 1'b1;
        if (cnt_last) begin
          cnt_nxt   = '0;
          state_nxt = ST_EMIT;
        end else begin
          cnt_nxt   = cnt_r + CW'(1);
          state_nxt = ST_PICK;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          cmd.emit      = 1'b1;
          out_valid_nxt = 1'b1;
          out_sing_nxt  = 1'b0;
          out_last_nxt  = cnt_last;
          if (cnt_last) begin
            cnt_nxt   = '0;
            state_nxt = ST_LOAD;
          end else begin
            cnt_nxt = cnt_r + CW'(1);
          end
        end
      end
      ST_SING: begin
        if (out_free) begin
          cmd.sing      = 1'b1;
          out_valid_nxt = 1'b1;
          out_sing_nxt  = 1'b1;
          out_last_nxt  = 1'b1;
          cnt_nxt       = '0;
          state_nxt     = ST_LOAD;
        end
      end
      default: begin
        cnt_nxt   = '0;
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_sing_r <= out_sing_nxt;
    out_last_r <= out_last_nxt;
  end

  assign idx          = cnt_r;
  assign out_valid    = out_valid_r;
  assign out_singular = out_sing_r;
  assign out_last_row = out_last_r;

endmodule

// File: sv/gf2_matrix_inverse_unit.sv
// Top level of the GF(2) matrix inverse unit: Gauss-Jordan over DIM x DIM bits.
//
//   channel | ports                                                         | carries
//   --------+---------------------------------------------------------------+---------------
//   in      | in_valid, in_ready, in_row_bits                               | matrix rows
//   out     | out_valid, out_ready, out_inverse_row, out_singular, out_last_row | inverse rows
//
// Rows load at one per cycle while the block is in its load state. After the last row, each
// column is a pivot pick, then an XOR into all row lanes at once; elimination stops at
// the first column with no pivot. Results then leave at one per cycle while out_ready
// allows. Synchronous active-low reset clears only control state. A stalled output
// holds the block in its output state; rows of the next matrix are taken while the
// final result still waits.
module gf2_matrix_inverse_unit #(
  parameter int unsigned DIM = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [gmi_pkg::ROW_W-1:0] in_row_bits,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [gmi_pkg::ROW_W-1:0] out_inverse_row,
  output logic                      out_singular,
  output logic                      out_last_row
);

  localparam int unsigned CW = $clog2(DIM);

  gmi_pkg::cmd_t    cmd;
  gmi_pkg::status_t status;
  logic [CW-1:0]    idx;

  gmi_ctrl #(
    .DIM (DIM),
    .CW  (CW)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_singular (out_singular),
    .out_last_row (out_last_row),
    .cmd          (cmd),
    .idx          (idx),
    .status       (status)
  );

  gmi_datapath #(
    .DIM (DIM),
    .CW  (CW)
  ) u_datapath (
    .clk             (clk),
    .cmd             (cmd),
    .idx             (idx),
    .in_row_bits     (in_row_bits),
    .status          (status),
    .out_inverse_row (out_inverse_row)
  );

endmodule

// File: sv/gmi_checker.sv
// Port-level checks for the GF(2) matrix inverse unit, bound to the top level.
module gmi_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic [gmi_pkg::ROW_W-1:0] in_row_bits,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [gmi_pkg::ROW_W-1:0] out_inverse_row,
  input logic                      out_singular,
  input logic                      out_last_row
);

  // No result is shown in the cycle after reset.
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_inverse_row)
      && $stable(out_singular) && $stable(out_last_row))
    else $error("stalled result changed");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_row_bits))
    else $error("stalled input item changed");

  // A singular matrix gives one all-zero result that closes the matrix.
  a_sing_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_singular |-> out_last_row && (out_inverse_row == '0))
    else $error("malformed singular result");

  // While inverse rows are still being sent, no new row is taken.
  a_no_load_mid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_row |-> !in_ready)
    else $error("input taken during result output");

endmodule

bind gf2_matrix_inverse_unit gmi_checker u_gmi_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .in_row_bits     (in_row_bits),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_inverse_row (out_inverse_row),
  .out_singular    (out_singular),
  .out_last_row    (out_last_row)
);

// File: tb/sv/gf2_inverse_checker.sv
// Checker for the GF(2) matrix inverse unit: predicts each inverse and compares every result.
module gf2_inverse_checker #(
  parameter int unsigned DIM = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic [gmi_pkg::ROW_W-1:0] in_row_bits,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  logic [gmi_pkg::ROW_W-1:0] out_inverse_row,
  input  logic                      out_singular,
  input  logic                      out_last_row,
  output int unsigned               fault_count,
  output int unsigned               pending_results
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ROW_W = gmi_pkg::ROW_W;

  typedef struct packed {
    logic [ROW_W-1:0] inverse_row;
    logic             singular;
    logic             last_row;
  } inverse_result_t;

  // Columns at or above DIM never reach the stored rows.
  localparam logic [ROW_W-1:0] COLUMN_MASK =
    (DIM >= ROW_W) ? '1 : ((ROW_W'(1) << DIM) - ROW_W'(1));

  logic [ROW_W-1:0] matrix_rows [DIM];
  int unsigned      rows_held;
  inverse_result_t  inverse_queue [$];

  initial begin
    fault_count = 0;
    pending_results = 0;
    rows_held = 0;
  end

  function automatic void log_fault(input string what, input inverse_result_t wanted,
                                    input inverse_result_t seen);
    if (fault_count < 10) begin
      $display("%0t: %s: expected row %h singular %b last %b, got row %h singular %b last %b",
               $realtime, what, wanted.inverse_row, wanted.singular, wanted.last_row,
               seen.inverse_row, seen.singular, seen.last_row);
    end
    fault_count++;
  endfunction

  function automatic void queue_expected(input inverse_result_t entry);
    inverse_queue.insert(inverse_queue.size(), entry);
  endfunction

  // Gauss-Jordan on a copy of the loaded rows, identity alongside.
  function automatic void predict_inverse();
    logic [ROW_W-1:0] work [DIM];
    logic [ROW_W-1:0] companion [DIM];
    logic [ROW_W-1:0] swap_row;
    int               pivot;
    bit               no_pivot;
    no_pivot = 1'b0;
    for (int r = 0; r < DIM; r++) begin
      work[r] = matrix_rows[r];
      companion[r] = (r < ROW_W) ? (ROW_W'(1) << r) : '0;
    end
    for (int col = 0; col < DIM && !no_pivot; col++) begin
      if (col >= ROW_W) begin
        no_pivot = 1'b1;
      end else begin
        pivot = col;
        while (pivot < DIM && !work[pivot][col]) pivot++;
        if (pivot >= DIM) begin
          no_pivot = 1'b1;
        end else begin
          swap_row = work[col];
          work[col] = work[pivot];
          work[pivot] = swap_row;
          swap_row = companion[col];
          companion[col] = companion[pivot];
          companion[pivot] = swap_row;
          for (int r = 0; r < DIM; r++) begin
            if (r != col && work[r][col]) begin
              work[r] ^= work[col];
              companion[r] ^= companion[col];
            end
          end
        end
      end
    end
    if (no_pivot) begin
      queue_expected('{inverse_row: '0, singular: 1'b1, last_row: 1'b1});
    end else begin
      for (int r = 0; r < DIM; r++) begin
        queue_expected('{inverse_row: companion[r], singular: 1'b0,
                         last_row: (r == DIM - 1)});
      end
    end
  endfunction

  always @(posedge clk) begin
    inverse_result_t seen;
    inverse_result_t wanted;
    if (!rst_n) begin
      rows_held = 0;
    end else begin
      if (out_valid && out_ready) begin
        seen = '{inverse_row: out_inverse_row, singular: out_singular,
                 last_row: out_last_row};
        if (inverse_queue.size() == 0) begin
          log_fault("result with none expected", '0, seen);
        end else begin
          wanted = inverse_queue.pop_front();
          if (seen.inverse_row !== wanted.inverse_row || seen.singular !== wanted.singular ||
              seen.last_row !== wanted.last_row) begin
            log_fault("inverse mismatch", wanted, seen);
          end
        end
      end
      if (in_valid && in_ready) begin
        matrix_rows[rows_held] = in_row_bits & COLUMN_MASK;
        rows_held++;
        if (rows_held == DIM) begin
          rows_held = 0;
          predict_inverse();
        end
      end
      pending_results = inverse_queue.size();
    end
  end

endmodule

// File: tb/sv/gf2_matrix_inverse_unit_test.sv
// Testbench top for the GF(2) matrix inverse unit: matrix stimulus, output stalls and verdict.
module gf2_matrix_inverse_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ROW_W = gmi_pkg::ROW_W;

  localparam int unsigned DIM = 32;
  localparam int unsigned RANDOM_MATRICES = 10;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [ROW_W-1:0] in_row_bits = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [ROW_W-1:0] out_inverse_row;
  logic             out_singular;
  logic             out_last_row;
  int unsigned      fault_count;
  int unsigned      pending_results;

  bit               sender_gaps = 1'b1;
  bit               receiver_stalls = 1'b1;
  logic [ROW_W-1:0] matrix_stage [DIM];

  gf2_matrix_inverse_unit #(.DIM(DIM)) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_row_bits     (in_row_bits),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_inverse_row (out_inverse_row),
    .out_singular    (out_singular),
    .out_last_row    (out_last_row)
  );

  gf2_inverse_checker #(.DIM(DIM)) u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_row_bits     (in_row_bits),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_inverse_row (out_inverse_row),
    .out_singular    (out_singular),
    .out_last_row    (out_last_row),
    .fault_count     (fault_count),
    .pending_results (pending_results)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(negedge clk) begin
    out_ready <= !receiver_stalls || ($urandom_range(99) >= 31);
  end

  initial begin
    #2ms;
    $display("gf2_matrix_inverse_unit_test: errors");
    $finish;
  end

  // Called at a falling edge; returns at the falling edge after the item is taken.
  task automatic send_row(input logic [ROW_W-1:0] row);
    while (sender_gaps && $urandom_range(99) < 31) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_row_bits <= row;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_matrix();
    for (int i = 0; i < DIM; i++) send_row(matrix_stage[i]);
  endtask

  // A shuffled identity mixed by random row additions stays invertible.
  task automatic build_invertible();
    logic [ROW_W-1:0] held;
    int unsigned      j;
    int unsigned      k;
    for (int i = 0; i < DIM; i++) matrix_stage[i] = ROW_W'(1) << i;
    for (int i = DIM - 1; i > 0; i--) begin
      j = $urandom_range(i);
      held = matrix_stage[i];
      matrix_stage[i] = matrix_stage[j];
      matrix_stage[j] = held;
    end
    for (int n = 0; n < 8 * DIM; n++) begin
      j = $urandom_range(DIM - 1);
      k = $urandom_range(DIM - 1);
      if (j != k) matrix_stage[j] ^= matrix_stage[k];
    end
  endtask

  // Replaces one row by zero, a copy of another row, or the sum of two other rows, which may coincide.
  task automatic make_dependent();
    int unsigned victim;
    int unsigned first;
    int unsigned second;
    victim = $urandom_range(DIM - 1);
    first = (victim + 1 + $urandom_range(DIM - 2)) % DIM;
    second = (victim + 1 + $urandom_range(DIM - 2)) % DIM;
    case ($urandom_range(2))
      0: begin
        matrix_stage[victim] = '0;
      end
      1: begin
        matrix_stage[victim] = matrix_stage[first];
      end
      default: begin
        matrix_stage[victim] = matrix_stage[first] ^ matrix_stage[second];
      end
    endcase
  endtask

  initial begin
    int unsigned kind;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Staircase of ones: row 0 holds only the top column, the last row is all ones,
    // so column 0 finds its pivot only in the last row.
    for (int i = 0; i < DIM; i++) matrix_stage[i] = {ROW_W{1'b1}} << (DIM - 1 - i);
    send_matrix();
    // Identity with a zero last row runs out of pivots only at the last column.
    for (int i = 0; i < DIM; i++) matrix_stage[i] = ROW_W'(1) << i;
    matrix_stage[DIM - 1] = '0;
    send_matrix();

    for (int m = 0; m < RANDOM_MATRICES; m++) begin
      sender_gaps = !(m >= 5 && m <= 7);
      receiver_stalls = sender_gaps;
      if (m == 3) begin
        in_valid <= 1'b0;
        wait (pending_results == 0);
        @(negedge clk);
      end
      kind = $urandom_range(9);
      if (kind <= 5) begin
        build_invertible();
      end else if (kind <= 7) begin
        build_invertible();
        make_dependent();
      end else begin
        for (int i = 0; i < DIM; i++) matrix_stage[i] = $urandom();
      end
      send_matrix();
    end
    in_valid <= 1'b0;

    wait (pending_results == 0);
    repeat (4 * DIM + 16) @(posedge clk);
    if (fault_count == 0 && pending_results == 0) begin
      $display("gf2_matrix_inverse_unit_test: clean");
    end else begin
      $display("gf2_matrix_inverse_unit_test: errors");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/gmi_pkg.sv
sv/gmi_datapath.sv
sv/gmi_ctrl.sv
sv/gf2_matrix_inverse_unit.sv
sv/gmi_checker.sv
tb/sv/gf2_inverse_checker.sv
tb/sv/gf2_matrix_inverse_unit_test.sv
